// ===== rtl/pdb_pkg.sv =====
// ----------------------------------------------------------------------------
// pdb_pkg
// Shared types and constants of the particle density binner: command codes,
// register indexes, store entry layout and the item passed down the pipeline.
// ----------------------------------------------------------------------------
package pdb_pkg;

    localparam int CFG_ADDR_W = 5;

    localparam logic [31:0] COUNT_FULL = 32'hFFFF_FFFF;
    localparam logic [47:0] MASS_FULL  = 48'hFFFF_FFFF_FFFF;

    localparam logic [31:0] INV_RESET  = 32'h0001_0000;
    localparam logic [8:0]  BINS_RESET = 9'd256;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_MIN_X  = 3'd0;
    localparam logic [2:0] REG_MIN_Y  = 3'd1;
    localparam logic [2:0] REG_INV_DX = 3'd2;
    localparam logic [2:0] REG_INV_DY = 3'd3;
    localparam logic [2:0] REG_BINS_X = 3'd4;
    localparam logic [2:0] REG_BINS_Y = 3'd5;

    typedef enum logic [1:0] {
        CMD_ACCUM      = 2'd0,
        CMD_READ       = 2'd1,
        CMD_READ_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } state_t;

    typedef struct packed {
        logic [31:0] count;
        logic [47:0] mass;
    } entry_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] mass;
        logic [15:0] cell_index;
        logic        oob;
    } item_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic [31:0]        inv_dx;
        logic [31:0]        inv_dy;
    } cfg_t;

endpackage

// ===== rtl/particle_density_binner_2d.sv =====
// ----------------------------------------------------------------------------
// particle_density_binner_2d
// Weighted 2D histogram: per-cell particle count and mass sum in one store.
// ----------------------------------------------------------------------------
// The input channel (s_*) takes one beat per command: accumulate a particle at
// (s_pos_x, s_pos_y) with s_mass, read the cell s_read_cell, or read and then
// clear it. Every accumulate or read beat gives one result beat on the m_*
// channel with the cell index, its count, its mass sum and a saturation flag;
// command 3 is taken and gives no result.
// The result passes through the index pipeline of four stages, the store read
// register and the result register.
// Throughput: one beat per cycle while m_ready does not stall it. Back-to-back
// hits on the same cell are forwarded around the store's registered read.
// After reset the store is swept to zero, one cell per cycle, over all
// MAX_BINS_X * MAX_BINS_Y cells (65536 at the default size); s_ready stays
// low until the sweep ends. Registers can be written at any time but are
// only meant to change while no beats are in flight.
// When m_ready is low with a result waiting, the whole pipeline holds and
// s_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module particle_density_binner_2d #(
    parameter int MAX_BINS_X = 256,
    parameter int MAX_BINS_Y = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pdb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_command,
    input  logic signed [31:0]             s_pos_x,
    input  logic signed [31:0]             s_pos_y,
    input  logic [31:0]                    s_mass,
    input  logic [15:0]                    s_read_cell,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_cell_index,
    output logic [31:0]                    m_particle_count,
    output logic [47:0]                    m_mass_total,
    output logic                           m_saturated
);

    localparam int NXW    = $clog2(MAX_BINS_X + 1);
    localparam int NYW    = $clog2(MAX_BINS_Y + 1);
    localparam int DEPTH  = MAX_BINS_X * MAX_BINS_Y;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

    pdb_pkg::cfg_t     cfg;
    logic [NXW-1:0]    nx;
    logic [NYW-1:0]    ny;
    logic [NXW+NYW-1:0] cells;

    pdb_pkg::state_t   state_reg;
    pdb_pkg::state_t   state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clearing;

    logic              adv;
    logic              take;
    logic              d_valid;
    pdb_pkg::item_t    d_item;
    logic [ADDR_W-1:0] d_addr;
    pdb_pkg::entry_t   rd_data;
    logic              upd_wr_en;
    logic [ADDR_W-1:0] upd_wr_addr;
    pdb_pkg::entry_t   upd_wr_data;
    logic              st_wr_en;
    logic [ADDR_W-1:0] st_wr_addr;
    pdb_pkg::entry_t   st_wr_data;

    pdb_cfg #(
        .MAX_BINS_X (MAX_BINS_X),
        .MAX_BINS_Y (MAX_BINS_Y)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .nx      (nx),
        .ny      (ny),
        .cells   (cells)
    );

    // reset sweep of the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pdb_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        clearing      = 1'b0;
        case (state_reg)
            pdb_pkg::ST_CLEAR: begin
                clearing      = 1'b1;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == CLR_LAST) begin
                    state_next    = pdb_pkg::ST_RUN;
                    clr_addr_next = '0;
                end
            end
            pdb_pkg::ST_RUN: begin
                clearing = 1'b0;
            end
            default: begin
                state_next = pdb_pkg::ST_CLEAR;
            end
        endcase
    end

    // whole pipeline moves when the result register is free or draining
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv && !clearing;
    assign take    = s_valid && s_ready;

    pdb_index #(
        .MAX_BINS_X (MAX_BINS_X),
        .MAX_BINS_Y (MAX_BINS_Y)
    ) u_index (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (adv),
        .take         (take),
        .in_command   (s_command),
        .in_pos_x     (s_pos_x),
        .in_pos_y     (s_pos_y),
        .in_mass      (s_mass),
        .in_read_cell (s_read_cell),
        .cfg          (cfg),
        .nx           (nx),
        .ny           (ny),
        .cells        (cells),
        .d_valid      (d_valid),
        .d_item       (d_item),
        .d_addr       (d_addr)
    );

    assign st_wr_en   = clearing ? 1'b1 : upd_wr_en;
    assign st_wr_addr = clearing ? clr_addr_reg : upd_wr_addr;
    assign st_wr_data = clearing ? '0 : upd_wr_data;

    pdb_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (adv),
        .rd_addr (d_addr),
        .rd_data (rd_data)
    );

    pdb_update #(
        .ADDR_W (ADDR_W)
    ) u_update (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (adv),
        .d_valid        (d_valid),
        .d_item         (d_item),
        .d_addr         (d_addr),
        .rd_data        (rd_data),
        .wr_en          (upd_wr_en),
        .wr_addr        (upd_wr_addr),
        .wr_data        (upd_wr_data),
        .out_valid      (m_valid),
        .out_cell_index (m_cell_index),
        .out_count      (m_particle_count),
        .out_mass       (m_mass_total),
        .out_saturated  (m_saturated)
    );

`ifndef SYNTHESIS
    a_no_beat_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pdb_pkg::ST_CLEAR |-> !s_ready)
        else $error("input beat possible during store sweep");

    a_no_update_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pdb_pkg::ST_CLEAR |-> !upd_wr_en)
        else $error("cell update collides with store sweep");

    a_sweep_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pdb_pkg::ST_RUN |=> state_reg == pdb_pkg::ST_RUN)
        else $error("store sweep restarted without reset");

    a_ready_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("input taken while result register is stalled");
`endif

endmodule

// ===== rtl/pdb_cfg.sv =====
// ----------------------------------------------------------------------------
// pdb_cfg
// Register file behind the APB-style port, plus the effective bin counts and
// the cell total derived from it.
// ----------------------------------------------------------------------------
module pdb_cfg #(
    parameter int MAX_BINS_X = 256,
    parameter int MAX_BINS_Y = 256,
    localparam int NXW = $clog2(MAX_BINS_X + 1),
    localparam int NYW = $clog2(MAX_BINS_Y + 1)
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pdb_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    output pdb_pkg::cfg_t                         cfg,
    output logic [NXW-1:0]                        nx,
    output logic [NYW-1:0]                        ny,
    output logic [NXW+NYW-1:0]                    cells
);

    logic [31:0]        min_x_reg;
    logic [31:0]        min_y_reg;
    logic [31:0]        inv_dx_reg;
    logic [31:0]        inv_dy_reg;
    logic [8:0]         bins_x_reg;
    logic [8:0]         bins_y_reg;
    logic [NXW-1:0]     nx_reg;
    logic [NYW-1:0]     ny_reg;
    logic [NXW+NYW-1:0] cells_reg;
    logic [2:0]         reg_idx;
    logic               wr_stb;

    assign reg_idx = paddr[pdb_pkg::CFG_ADDR_W-1:2];
    assign wr_stb  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg  <= '0;
            min_y_reg  <= '0;
            inv_dx_reg <= pdb_pkg::INV_RESET;
            inv_dy_reg <= pdb_pkg::INV_RESET;
            bins_x_reg <= pdb_pkg::BINS_RESET;
            bins_y_reg <= pdb_pkg::BINS_RESET;
        end else if (wr_stb) begin
            case (reg_idx)
                pdb_pkg::REG_MIN_X:  min_x_reg  <= pwdata;
                pdb_pkg::REG_MIN_Y:  min_y_reg  <= pwdata;
                pdb_pkg::REG_INV_DX: inv_dx_reg <= pwdata;
                pdb_pkg::REG_INV_DY: inv_dy_reg <= pwdata;
                pdb_pkg::REG_BINS_X: bins_x_reg <= pwdata[8:0];
                pdb_pkg::REG_BINS_Y: bins_y_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pdb_pkg::REG_MIN_X:  prdata = min_x_reg;
            pdb_pkg::REG_MIN_Y:  prdata = min_y_reg;
            pdb_pkg::REG_INV_DX: prdata = inv_dx_reg;
            pdb_pkg::REG_INV_DY: prdata = inv_dy_reg;
            pdb_pkg::REG_BINS_X: prdata = 32'(bins_x_reg);
            pdb_pkg::REG_BINS_Y: prdata = 32'(bins_y_reg);
            default:             prdata = '0;
        endcase
    end

    // zero counts as one bin, anything past the maximum counts as the maximum
    always_ff @(posedge aclk) begin
        if (bins_x_reg == '0) begin
            nx_reg <= NXW'(1);
        end else if (32'(bins_x_reg) > 32'(MAX_BINS_X)) begin
            nx_reg <= NXW'(MAX_BINS_X);
        end else begin
            nx_reg <= NXW'(bins_x_reg);
        end
        if (bins_y_reg == '0) begin
            ny_reg <= NYW'(1);
        end else if (32'(bins_y_reg) > 32'(MAX_BINS_Y)) begin
            ny_reg <= NYW'(MAX_BINS_Y);
        end else begin
            ny_reg <= NYW'(bins_y_reg);
        end
        cells_reg <= (NXW+NYW)'(nx_reg) * (NXW+NYW)'(ny_reg);
    end

    assign cfg.min_x  = min_x_reg;
    assign cfg.min_y  = min_y_reg;
    assign cfg.inv_dx = inv_dx_reg;
    assign cfg.inv_dy = inv_dy_reg;
    assign nx         = nx_reg;
    assign ny         = ny_reg;
    assign cells      = cells_reg;

endmodule

// ===== rtl/pdb_index.sv =====
// ----------------------------------------------------------------------------
// pdb_index
// Four-stage cell address pipeline: offset from origin, scale by the
// reciprocal spacing, clamp to the grid, then row * bins_x + column.
// ----------------------------------------------------------------------------
module pdb_index #(
    parameter int MAX_BINS_X = 256,
    parameter int MAX_BINS_Y = 256,
    localparam int NXW    = $clog2(MAX_BINS_X + 1),
    localparam int NYW    = $clog2(MAX_BINS_Y + 1),
    localparam int ADDR_W = $clog2(MAX_BINS_X * MAX_BINS_Y)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      take,
    input  logic [1:0]                in_command,
    input  logic signed [31:0]        in_pos_x,
    input  logic signed [31:0]        in_pos_y,
    input  logic [31:0]               in_mass,
    input  logic [15:0]               in_read_cell,
    input  pdb_pkg::cfg_t             cfg,
    input  logic [NXW-1:0]            nx,
    input  logic [NYW-1:0]            ny,
    input  logic [NXW+NYW-1:0]        cells,
    output logic                      d_valid,
    output pdb_pkg::item_t            d_item,
    output logic [ADDR_W-1:0]         d_addr
);

    localparam int CXW = $clog2(MAX_BINS_X);
    localparam int CYW = $clog2(MAX_BINS_Y);
    localparam int PW  = CYW + NXW + 1;

    logic [33:0]       diff_x;
    logic [33:0]       diff_y;
    logic [31:0]       off_x;
    logic [31:0]       off_y;
    logic [63:0]       prod_x;
    logic [63:0]       prod_y;
    logic [CXW-1:0]    col_next;
    logic [CYW-1:0]    row_next;
    logic [PW-1:0]     lin;
    pdb_pkg::item_t    a_item_next;
    pdb_pkg::item_t    d_item_next;
    logic [ADDR_W-1:0] d_addr_next;
    logic              is_accum;

    logic              a_valid_reg;
    logic              b_valid_reg;
    logic              c_valid_reg;
    logic              d_valid_reg;
    pdb_pkg::item_t    a_item_reg;
    pdb_pkg::item_t    b_item_reg;
    pdb_pkg::item_t    c_item_reg;
    pdb_pkg::item_t    d_item_reg;
    logic [31:0]       a_off_x_reg;
    logic [31:0]       a_off_y_reg;
    logic [31:0]       b_idx_x_reg;
    logic [31:0]       b_idx_y_reg;
    logic [CXW-1:0]    c_col_reg;
    logic [CYW-1:0]    c_row_reg;
    logic [ADDR_W-1:0] d_addr_reg;

    // positions at or below the origin give a zero offset
    assign diff_x = {{2{in_pos_x[31]}}, in_pos_x} - {{2{cfg.min_x[31]}}, cfg.min_x};
    assign diff_y = {{2{in_pos_y[31]}}, in_pos_y} - {{2{cfg.min_y[31]}}, cfg.min_y};
    assign off_x  = (!diff_x[33] && diff_x != '0) ? diff_x[31:0] : '0;
    assign off_y  = (!diff_y[33] && diff_y != '0) ? diff_y[31:0] : '0;

    always_comb begin
        a_item_next.cmd        = pdb_pkg::cmd_t'(in_command);
        a_item_next.mass       = in_mass;
        a_item_next.cell_index = in_read_cell;
        a_item_next.oob        = 1'b0;
    end

    // Q32.32 product, integer part is the bin
    assign prod_x = {32'd0, a_off_x_reg} * {32'd0, cfg.inv_dx};
    assign prod_y = {32'd0, a_off_y_reg} * {32'd0, cfg.inv_dy};

    assign col_next = (b_idx_x_reg >= 32'(nx)) ? CXW'(nx - NXW'(1)) : CXW'(b_idx_x_reg);
    assign row_next = (b_idx_y_reg >= 32'(ny)) ? CYW'(ny - NYW'(1)) : CYW'(b_idx_y_reg);

    assign lin      = PW'(c_row_reg) * PW'(nx) + PW'(c_col_reg);
    assign is_accum = (c_item_reg.cmd == pdb_pkg::CMD_ACCUM);

    always_comb begin
        d_item_next = c_item_reg;
        if (is_accum) begin
            d_item_next.cell_index = 16'(lin);
            d_item_next.oob        = 1'b0;
            d_addr_next            = ADDR_W'(lin);
        end else begin
            d_item_next.oob = (32'(c_item_reg.cell_index) >= 32'(cells));
            d_addr_next     = ADDR_W'(c_item_reg.cell_index);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            // the unused command is taken and dropped here
            a_valid_reg <= take && (in_command == pdb_pkg::CMD_ACCUM ||
                                    in_command == pdb_pkg::CMD_READ ||
                                    in_command == pdb_pkg::CMD_READ_CLEAR);
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_item_reg  <= a_item_next;
            a_off_x_reg <= off_x;
            a_off_y_reg <= off_y;
            b_item_reg  <= a_item_reg;
            b_idx_x_reg <= prod_x[63:32];
            b_idx_y_reg <= prod_y[63:32];
            c_item_reg  <= b_item_reg;
            c_col_reg   <= col_next;
            c_row_reg   <= row_next;
            d_item_reg  <= d_item_next;
            d_addr_reg  <= d_addr_next;
        end
    end

    assign d_valid = d_valid_reg;
    assign d_item  = d_item_reg;
    assign d_addr  = d_addr_reg;

endmodule

// ===== rtl/pdb_store.sv =====
// ----------------------------------------------------------------------------
// pdb_store
// Cell store: count and mass sum per cell, one write port and one read port
// with registered read data.
// ----------------------------------------------------------------------------
module pdb_store #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pdb_pkg::entry_t   wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output pdb_pkg::entry_t   rd_data
);

    pdb_pkg::entry_t mem [DEPTH];
    pdb_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pdb_update.sv =====
// ----------------------------------------------------------------------------
// pdb_update
// Read-modify-write stage: takes the cell read from the store, adds the
// particle or clears the cell, writes back and loads the result register.
// ----------------------------------------------------------------------------
module pdb_update #(
    parameter int ADDR_W = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              d_valid,
    input  pdb_pkg::item_t    d_item,
    input  logic [ADDR_W-1:0] d_addr,
    input  pdb_pkg::entry_t   rd_data,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output pdb_pkg::entry_t   wr_data,
    output logic              out_valid,
    output logic [15:0]       out_cell_index,
    output logic [31:0]       out_count,
    output logic [47:0]       out_mass,
    output logic              out_saturated
);

    logic              m_valid_reg;
    pdb_pkg::item_t    m_item_reg;
    logic [ADDR_W-1:0] m_addr_reg;
    logic              fwd_hit_reg;
    pdb_pkg::entry_t   fwd_data_reg;
    logic              o_valid_reg;
    logic [15:0]       o_cell_reg;
    logic [31:0]       o_count_reg;
    logic [47:0]       o_mass_reg;
    logic              o_sat_reg;

    pdb_pkg::entry_t   cur;
    pdb_pkg::entry_t   upd;
    pdb_pkg::entry_t   res;
    logic [48:0]       mass_sum;
    logic              wr_req;
    logic              fwd_hit_next;

    // the previous item's write landed with this read, so it is not in the read data
    assign cur      = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign mass_sum = {1'b0, cur.mass} + 49'(m_item_reg.mass);

    always_comb begin
        upd    = cur;
        res    = cur;
        wr_req = 1'b0;
        case (m_item_reg.cmd)
            pdb_pkg::CMD_ACCUM: begin
                upd.count = (cur.count == pdb_pkg::COUNT_FULL) ? pdb_pkg::COUNT_FULL
                                                               : cur.count + 32'd1;
                upd.mass  = mass_sum[48] ? pdb_pkg::MASS_FULL : mass_sum[47:0];
                res       = upd;
                wr_req    = 1'b1;
            end
            pdb_pkg::CMD_READ_CLEAR: begin
                upd    = '0;
                wr_req = !m_item_reg.oob;
            end
            default: ;
        endcase
        if (m_item_reg.oob) begin
            res = '0;
        end
    end

    assign wr_en        = en && m_valid_reg && wr_req;
    assign wr_addr      = m_addr_reg;
    assign wr_data      = upd;
    assign fwd_hit_next = wr_en && d_valid && (d_addr == m_addr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d_valid;
            fwd_hit_reg <= fwd_hit_next;
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_item_reg   <= d_item;
            m_addr_reg   <= d_addr;
            fwd_data_reg <= upd;
            o_cell_reg   <= m_item_reg.cell_index;
            o_count_reg  <= res.count;
            o_mass_reg   <= res.mass;
            o_sat_reg    <= (res.count == pdb_pkg::COUNT_FULL) ||
                            (res.mass == pdb_pkg::MASS_FULL);
        end
    end

    assign out_valid      = o_valid_reg;
    assign out_cell_index = o_cell_reg;
    assign out_count      = o_count_reg;
    assign out_mass       = o_mass_reg;
    assign out_saturated  = o_sat_reg;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the 2D particle density binner. A short table of directed
// beats runs first, then several grid settings with mostly on-grid random
// particles and reads. Directed results are compared with the table, the random
// ones with a cycle-free model of the count and mass stores, and each register
// is read back after it is written.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BINS_X      = 256;
    localparam int MAX_BINS_Y      = 256;
    localparam int STORE_DEPTH     = MAX_BINS_X * MAX_BINS_Y;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PIPE_DRAIN      = 12;
    localparam int WATCHDOG_LIMIT  = 300000;
    localparam int LONG_HOLD       = 400;
    localparam int HOT_DEPTH       = 16;
    localparam int MAX_REPORTED    = 10;
    localparam longint POS_MAX     = 64'sd2147483647;
    localparam longint POS_MIN     = -64'sd2147483648;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        mass;
        logic [15:0]        read_cell;
    } particle_beat_t;

    typedef struct {
        logic [15:0] cell_index;
        logic [31:0] count;
        logic [47:0] mass;
        logic        sat;
    } cell_report_t;

    typedef struct {
        particle_beat_t beat;
        bit             typed;
        cell_report_t   want;
    } directed_row_t;

    typedef struct {
        logic [31:0] min_x;
        logic [31:0] min_y;
        logic [31:0] inv_dx;
        logic [31:0] inv_dy;
        logic [8:0]  bins_x;
        logic [8:0]  bins_y;
        bit          write_regs;
        bit          shuffle;
        int          items;
    } grid_phase_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [pdb_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [1:0]                     s_command = pdb_pkg::CMD_ACCUM;
    logic signed [31:0]             s_pos_x = '0;
    logic signed [31:0]             s_pos_y = '0;
    logic [31:0]                    s_mass = '0;
    logic [15:0]                    s_read_cell = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [15:0]                    m_cell_index;
    logic [31:0]                    m_particle_count;
    logic [47:0]                    m_mass_total;
    logic                           m_saturated;

    // model of the grid registers and both stores
    logic signed [31:0] grid_min_x = '0;
    logic signed [31:0] grid_min_y = '0;
    logic [31:0]        grid_inv_dx = pdb_pkg::INV_RESET;
    logic [31:0]        grid_inv_dy = pdb_pkg::INV_RESET;
    logic [8:0]         grid_bins_x = pdb_pkg::BINS_RESET;
    logic [8:0]         grid_bins_y = pdb_pkg::BINS_RESET;
    bit [31:0]          cell_counts [STORE_DEPTH];
    bit [47:0]          cell_mass [STORE_DEPTH];

    cell_report_t pending_reports [$];
    int unsigned  hot_cells [$];
    cell_report_t seen_want;
    int           burst_left = 0;
    int           mismatches = 0;
    int           idle_cycles = 0;
    bit           long_hold_req = 1'b0;

    directed_row_t directed_rows [17] = '{
        '{'{pdb_pkg::CMD_READ, 32'sh0, 32'sh0, 32'h0, 16'd0}, 1'b1,
          '{16'd0, 32'd0, 48'd0, 1'b0}},
        '{'{pdb_pkg::CMD_READ, 32'sh0, 32'sh0, 32'h0, 16'd65535}, 1'b1,
          '{16'd65535, 32'd0, 48'd0, 1'b0}},
        '{'{pdb_pkg::CMD_ACCUM, 32'sh0, 32'sh0, 32'hFFFF_FFFF, 16'd0}, 1'b1,
          '{16'd0, 32'd1, 48'hFFFF_FFFF, 1'b0}},
        '{'{pdb_pkg::CMD_ACCUM, 32'sh8000_0000, 32'sh8000_0000, 32'h0, 16'hFFFF}, 1'b1,
          '{16'd0, 32'd2, 48'hFFFF_FFFF, 1'b0}},
        '{'{pdb_pkg::CMD_ACCUM, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h1, 16'd0}, 1'b1,
          '{16'd65535, 32'd1, 48'd1, 1'b0}},
        '{'{pdb_pkg::CMD_ACCUM, 32'sh0001_0000, 32'sh0002_0000, 32'h0001_8000, 16'd0}, 1'b1,
          '{16'd513, 32'd1, 48'h1_8000, 1'b0}},
        '{'{pdb_pkg::CMD_ACCUM, 32'sh0000_FFFF, 32'sh0000_FFFF, 32'h10, 16'd0}, 1'b1,
          '{16'd0, 32'd3, 48'h1_0000_000F, 1'b0}},
        '{'{pdb_pkg::CMD_READ_CLEAR, 32'sh0, 32'sh0, 32'h0, 16'd0}, 1'b1,
          '{16'd0, 32'd3, 48'h1_0000_000F, 1'b0}},
        '{'{pdb_pkg::CMD_READ, 32'sh0, 32'sh0, 32'h0, 16'd0}, 1'b1,
          '{16'd0, 32'd0, 48'd0, 1'b0}},
        '{'{CMD_UNUSED, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF, 16'd513}, 1'b0,
          '{16'd0, 32'd0, 48'd0, 1'b0}},
        '{'{pdb_pkg::CMD_READ, 32'sh0, 32'sh0, 32'h0, 16'd513}, 1'b1,
          '{16'd513, 32'd1, 48'h1_8000, 1'b0}},
        '{'{pdb_pkg::CMD_ACCUM, 32'sh00FF_0000, 32'sh00FE_8000, 32'hAAAA_AAAA, 16'd0}, 1'b1,
          '{16'd65279, 32'd1, 48'hAAAA_AAAA, 1'b0}},
        '{'{pdb_pkg::CMD_ACCUM, 32'sh0100_0000, 32'sh00FE_FFFF, 32'h5555_5555, 16'd0}, 1'b1,
          '{16'd65279, 32'd2, 48'hFFFF_FFFF, 1'b0}},
        '{'{pdb_pkg::CMD_ACCUM, 32'shFFFF_0000, 32'sh0001_0000, 32'h8000_0000, 16'd0}, 1'b1,
          '{16'd256, 32'd1, 48'h8000_0000, 1'b0}},
        '{'{pdb_pkg::CMD_READ_CLEAR, 32'sh0, 32'sh0, 32'h0, 16'd65535}, 1'b1,
          '{16'd65535, 32'd1, 48'd1, 1'b0}},
        '{'{pdb_pkg::CMD_ACCUM, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h2, 16'd0}, 1'b1,
          '{16'd65535, 32'd1, 48'd2, 1'b0}},
        '{'{pdb_pkg::CMD_READ_CLEAR, 32'sh0, 32'sh0, 32'h0, 16'd65279}, 1'b1,
          '{16'd65279, 32'd2, 48'hFFFF_FFFF, 1'b0}}
    };

    grid_phase_t phase_plan [8] = '{
        '{32'h0, 32'h0, pdb_pkg::INV_RESET, pdb_pkg::INV_RESET,
          pdb_pkg::BINS_RESET, pdb_pkg::BINS_RESET, 1'b0, 1'b0, 280},
        '{32'hFFFB_0000, 32'h0003_4000, 32'h0002_0000, 32'h0000_8000, 9'd7, 9'd5,
          1'b1, 1'b0, 300},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 9'd0, 9'd511,
          1'b1, 1'b0, 220},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 9'd256, 9'd1,
          1'b1, 1'b0, 220},
        '{32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd4, 9'd4, 1'b1, 1'b0, 80},
        '{32'h0012_3456, 32'hFF80_0000, 32'h0000_3000, 32'h0010_0000, 9'd257, 9'd3,
          1'b1, 1'b0, 250},
        '{32'h0, 32'h0, 32'h0, 32'h0, 9'd0, 9'd0, 1'b1, 1'b1, 300},
        '{32'h0, 32'h0, 32'h0, 32'h0, 9'd0, 9'd0, 1'b1, 1'b1, 300}
    };

    particle_density_binner_2d #(
        .MAX_BINS_X(MAX_BINS_X),
        .MAX_BINS_Y(MAX_BINS_Y)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_mass          (s_mass),
        .s_read_cell     (s_read_cell),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cell_index    (m_cell_index),
        .m_particle_count(m_particle_count),
        .m_mass_total    (m_mass_total),
        .m_saturated     (m_saturated)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
            $display("mismatch %s: expected %h, got %h", what, want, got);
        end
    endfunction

    function automatic int unsigned bins_in_use(logic [8:0] b, int unsigned maxb);
        if (b == 9'd0) return 1;
        if (32'(b) > maxb) return maxb;
        return 32'(b);
    endfunction

    // integer part of the exact Q32.32 product of offset and reciprocal
    function automatic int unsigned axis_bin(logic signed [31:0] pos, logic signed [31:0] org,
                                             logic [31:0] inv, int unsigned n);
        longint      p;
        longint      o;
        logic [63:0] prod;
        logic [63:0] idx;
        p = longint'(pos);
        o = longint'(org);
        idx = '0;
        if (p > o) begin
            prod = 64'(p - o) * {32'd0, inv};
            idx = {32'd0, prod[63:32]};
        end
        if (idx >= 64'(n)) idx = 64'(n - 1);
        return idx[31:0];
    endfunction

    function automatic cell_report_t stored_cell(int unsigned cell_idx);
        cell_report_t r;
        r.cell_index = cell_idx[15:0];
        r.count = cell_counts[cell_idx];
        r.mass = cell_mass[cell_idx];
        r.sat = (cell_counts[cell_idx] == pdb_pkg::COUNT_FULL) ||
                (cell_mass[cell_idx] == pdb_pkg::MASS_FULL);
        return r;
    endfunction

    // updates the store model; returns 1 when the beat gives a result
    function automatic bit apply_beat(input particle_beat_t b, output cell_report_t rep);
        int unsigned nx;
        int unsigned ny;
        int unsigned cell_idx;
        logic [63:0] sum;
        nx = bins_in_use(grid_bins_x, MAX_BINS_X);
        ny = bins_in_use(grid_bins_y, MAX_BINS_Y);
        rep = '{16'd0, 32'd0, 48'd0, 1'b0};
        case (b.cmd)
            pdb_pkg::CMD_ACCUM: begin
                cell_idx = axis_bin(b.pos_y, grid_min_y, grid_inv_dy, ny) * nx
                         + axis_bin(b.pos_x, grid_min_x, grid_inv_dx, nx);
                sum = {16'd0, cell_mass[cell_idx]} + {32'd0, b.mass};
                if (sum > {16'd0, pdb_pkg::MASS_FULL}) sum = {16'd0, pdb_pkg::MASS_FULL};
                if (cell_counts[cell_idx] != pdb_pkg::COUNT_FULL) cell_counts[cell_idx]++;
                cell_mass[cell_idx] = sum[47:0];
                rep = stored_cell(cell_idx);
                hot_cells.push_back(cell_idx);
                if (hot_cells.size() > HOT_DEPTH) void'(hot_cells.pop_front());
            end
            pdb_pkg::CMD_READ, pdb_pkg::CMD_READ_CLEAR: begin
                cell_idx = 32'(b.read_cell);
                if (cell_idx >= nx * ny) begin
                    rep.cell_index = b.read_cell;
                end else begin
                    rep = stored_cell(cell_idx);
                    if (b.cmd == pdb_pkg::CMD_READ_CLEAR) begin
                        cell_counts[cell_idx] = '0;
                        cell_mass[cell_idx] = '0;
                    end
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // position spread over the grid and a little past both ends
    function automatic logic signed [31:0] near_grid(logic signed [31:0] org, logic [31:0] inv,
                                                     int unsigned n);
        longint w;
        longint span;
        longint p;
        w = (inv == 32'd0) ? (longint'(1) << 31) : ((longint'(1) << 32) / longint'(inv)) + 1;
        span = w * longint'(n + 1);
        p = longint'(org) - w / 2 + longint'({$urandom, $urandom} >> 1) % span;
        if (p > POS_MAX) p = POS_MAX;
        if (p < POS_MIN) p = POS_MIN;
        return p[31:0];
    endfunction

    function automatic particle_beat_t random_beat();
        particle_beat_t b;
        int unsigned    nx;
        int unsigned    ny;
        int unsigned    pick;
        nx = bins_in_use(grid_bins_x, MAX_BINS_X);
        ny = bins_in_use(grid_bins_y, MAX_BINS_Y);
        b.pos_x = $urandom;
        b.pos_y = $urandom;
        b.mass = $urandom;
        b.read_cell = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            b.cmd = pdb_pkg::CMD_ACCUM;
            b.pos_x = near_grid(grid_min_x, grid_inv_dx, nx);
            b.pos_y = near_grid(grid_min_y, grid_inv_dy, ny);
        end else if (pick < 65) begin
            b.cmd = pdb_pkg::CMD_ACCUM;
        end else if (pick < 90) begin
            b.cmd = (pick < 80) ? pdb_pkg::CMD_READ : pdb_pkg::CMD_READ_CLEAR;
            if (hot_cells.size() != 0 && $urandom_range(0, 1) == 1) begin
                b.read_cell = 16'(hot_cells[$urandom_range(0, hot_cells.size() - 1)]);
            end else begin
                b.read_cell = 16'($urandom_range(0, nx * ny - 1));
            end
        end else if (pick < 95) begin
            b.cmd = pick[0] ? pdb_pkg::CMD_READ : pdb_pkg::CMD_READ_CLEAR;
        end else begin
            b.cmd = CMD_UNUSED;
        end
        if ($urandom_range(0, 3) == 0) b.mass = $urandom_range(0, 255);
        return b;
    endfunction

    // offers one beat; the sender often idles between bursts
    task automatic offer_beat(input particle_beat_t b, input bit typed,
                              input cell_report_t typed_rep);
        cell_report_t rep;
        int           gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_command <= b.cmd;
        s_pos_x <= b.pos_x;
        s_pos_y <= b.pos_y;
        s_mass <= b.mass;
        s_read_cell <= b.read_cell;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        if (apply_beat(b, rep)) pending_reports.push_back(typed ? typed_rep : rep);
        @(posedge aclk);
    endtask

    // write then read back; leaves psel high so writes can chain
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        mask = (idx == pdb_pkg::REG_BINS_X || idx == pdb_pkg::REG_BINS_Y) ? 32'h0000_01FF
                                                                          : 32'hFFFF_FFFF;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (prdata !== (val & mask)) begin
            note_mismatch("register read-back", 64'(val & mask), 64'(prdata));
        end
        @(posedge aclk);
    endtask

    task automatic load_grid(input grid_phase_t ph);
        grid_min_x = ph.min_x;
        grid_min_y = ph.min_y;
        grid_inv_dx = ph.inv_dx;
        grid_inv_dy = ph.inv_dy;
        grid_bins_x = ph.bins_x;
        grid_bins_y = ph.bins_y;
        write_reg(pdb_pkg::REG_MIN_X, ph.min_x);
        write_reg(pdb_pkg::REG_MIN_Y, ph.min_y);
        write_reg(pdb_pkg::REG_INV_DX, ph.inv_dx);
        write_reg(pdb_pkg::REG_INV_DY, ph.inv_dy);
        write_reg(pdb_pkg::REG_BINS_X, {23'd0, ph.bins_x});
        write_reg(pdb_pkg::REG_BINS_Y, {23'd0, ph.bins_y});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // command 3 beats leave nothing queued, so allow the pipeline to empty too
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    initial begin
        particle_beat_t b;
        grid_phase_t    ph;
        cell_report_t   no_rep;
        int             sent;
        no_rep = '{16'd0, 32'd0, 48'd0, 1'b0};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[r]) begin
            offer_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);
        end
        foreach (phase_plan[k]) begin
            ph = phase_plan[k];
            if (ph.write_regs) begin
                drain_results();
                if (ph.shuffle) begin
                    ph.min_x = $urandom;
                    ph.min_y = $urandom;
                    ph.inv_dx = ($urandom_range(0, 3) == 0) ? $urandom
                              : $urandom_range(32'h100, 32'h0010_0000);
                    ph.inv_dy = ($urandom_range(0, 3) == 0) ? $urandom
                              : $urandom_range(32'h100, 32'h0010_0000);
                    ph.bins_x = 9'($urandom_range(0, 511));
                    ph.bins_y = 9'($urandom_range(0, 511));
                end
                load_grid(ph);
            end
            sent = 0;
            while (sent < ph.items) begin
                b = random_beat();
                if (ph.items > 200 && sent == ph.items / 2) long_hold_req = 1'b1;
                offer_beat(b, 1'b0, no_rep);
                if (b.cmd != CMD_UNUSED) sent++;
            end
        end
        drain_results();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // receiver: stall rate changes every stretch, with the odd long hold-off
    initial begin
        int stall_pct;
        int stretch;
        stall_pct = 0;
        stretch = 0;
        forever begin
            @(posedge aclk);
            if (stretch == 0) begin
                stretch = $urandom_range(32, 400);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            stretch--;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // a result beat seen here is taken at the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                note_mismatch("result beat with nothing pending", 64'd0, {48'd0, m_cell_index});
            end else begin
                seen_want = pending_reports.pop_front();
                if (m_cell_index !== seen_want.cell_index)
                    note_mismatch("cell_index", 64'(seen_want.cell_index), 64'(m_cell_index));
                if (m_particle_count !== seen_want.count)
                    note_mismatch("particle_count", 64'(seen_want.count),
                                  64'(m_particle_count));
                if (m_mass_total !== seen_want.mass)
                    note_mismatch("mass_total", 64'(seen_want.mass), 64'(m_mass_total));
                if (m_saturated !== seen_want.sat)
                    note_mismatch("saturated", 64'(seen_want.sat), 64'(m_saturated));
            end
        end
    end

    // covers the store sweep after reset and the long hold-offs
    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule

// ===== particle_density_binner_2d.f =====
rtl/pdb_pkg.sv
rtl/pdb_cfg.sv
rtl/pdb_index.sv
rtl/pdb_store.sv
rtl/pdb_update.sv
rtl/particle_density_binner_2d.sv
bench/tb_top.sv
